// ===== rtl/mww_pkg.sv =====
// ----------------------------------------------------------------------------
// mww_pkg
// Types and constants shared by the metering window weight block.
// ----------------------------------------------------------------------------
package mww_pkg;

  localparam int ROW_W      = 4;
  localparam int COL_W      = 5;
  localparam int WGT_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;
  localparam int PCT_W      = 7;
  localparam int CNT_W      = 12;
  localparam int W_W        = 23;
  localparam int QUO_W      = 27;
  localparam int DEN_W      = 18;
  localparam int SH_W       = 5;
  localparam int MULA_W     = 19;
  localparam int MULB_W     = 12;
  localparam int ITER_W     = 5;
  localparam int SCALE_SH   = 16;

  localparam int DEF_MAX_GRID_COLS = 32;
  localparam int DEF_MAX_GRID_ROWS = 16;

  localparam logic [PCT_W-1:0] PCT_TOTAL = PCT_W'(100);
  localparam logic [PCT_W-1:0] PCT_MIN   = PCT_W'(1);
  localparam logic [PCT_W-1:0] PCT_MAX   = PCT_W'(99);
  localparam logic [WGT_W-1:0] WGT_MAX   = WGT_W'(255);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_COLS       = 3'd0,
    REG_GRID_ROWS       = 3'd1,
    REG_INNER_COL_START = 3'd2,
    REG_INNER_ROW_START = 3'd3,
    REG_INNER_COLS      = 3'd4,
    REG_INNER_ROWS      = 3'd5,
    REG_INNER_SHARE_PCT = 3'd6
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TOTAL,
    ST_NIN,
    ST_CHECK,
    ST_DIV_OUT,
    ST_DIV_IN,
    ST_NORM,
    ST_ROUND,
    ST_PROD1,
    ST_PROD2,
    ST_DEN,
    ST_DIV_FIX,
    ST_OUT
  } state_t;

endpackage

// ===== rtl/mww_in_if.sv =====
// ----------------------------------------------------------------------------
// mww_in_if
// Query channel: one grid window position per transaction.
// ----------------------------------------------------------------------------
interface mww_in_if;
  import mww_pkg::*;

  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] cell_row;
  logic [COL_W-1:0] cell_col;

  modport source (output valid, output cell_row, output cell_col, input ready);
  modport sink   (input valid, input cell_row, input cell_col, output ready);

endinterface

// ===== rtl/mww_out_if.sv =====
// ----------------------------------------------------------------------------
// mww_out_if
// Result channel: weight and region error flag per transaction.
// ----------------------------------------------------------------------------
interface mww_out_if;
  import mww_pkg::*;

  logic             valid;
  logic             ready;
  logic [WGT_W-1:0] cell_weight;
  logic             region_error;

  modport source (output valid, output cell_weight, output region_error, input ready);
  modport sink   (input valid, input cell_weight, input region_error, output ready);

endinterface

// ===== rtl/metering_window_weight.sv =====
// ----------------------------------------------------------------------------
// metering_window_weight
// Exposure-metering weight of one grid window, computed on a shared
// multiplier and a shared one-bit-per-cycle restoring divider.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan  carries a window position (cell_row, cell_col); a transaction
//            completes when valid and ready are both high.
//   out_chan returns cell_weight and region_error for that window.
//   cfg_*    writes one setup register per cycle with cfg_wr_en high; write
//            only while no query is in flight.
// Sequence: when either region is empty, the setup states (total, inner count,
// check) lead straight to the result. Otherwise two divisions give the outer
// and inner weights, then normalisation, rounding, two products and the
// denominator follow, and one final division gives the weight.
// Flow: one query at a time; in_chan.ready is high only when idle, so a new
// query is taken only after the previous result has left on out_chan.
// Reset: the setup registers take their default grid (32 x 12, inner 16 x 6
// at origin, 50 percent) and the block returns to idle.
// Stall: the result is held in the output register until out_chan.ready.
// ----------------------------------------------------------------------------
module metering_window_weight
  import mww_pkg::*;
#(
  parameter int MAX_GRID_COLS = DEF_MAX_GRID_COLS,
  parameter int MAX_GRID_ROWS = DEF_MAX_GRID_ROWS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  mww_in_if.sink                in_chan,
  mww_out_if.source             out_chan
);

  state_t state_r, state_nxt;

  logic [5:0] grid_cols_r;
  logic [4:0] grid_rows_r;
  logic [4:0] inner_col_start_r;
  logic [3:0] inner_row_start_r;
  logic [5:0] inner_cols_r;
  logic [4:0] inner_rows_r;
  logic [6:0] inner_share_pct_r;

  logic [ROW_W-1:0] row_r;
  logic [COL_W-1:0] col_r;
  logic [CNT_W-1:0] total_r, nin_r, nout_r;
  logic [W_W-1:0]   wout_r, win_r, big_r;
  logic [SH_W-1:0]  sh_r;
  logic             sel_in_r;
  logic [QUO_W-1:0] prod_r;
  logic [WGT_W-1:0] weight_r;
  logic             err_r;

  logic [QUO_W-1:0]  div_q_r;
  logic [DEN_W-1:0]  div_rem_r, div_d_r;
  logic [ITER_W-1:0] div_cnt_r;

  logic [PCT_W-1:0]  pct, pct_c;
  logic [6:0]        gc;
  logic [5:0]        gr;
  logic [MULA_W-1:0] mul_a;
  logic [MULB_W-1:0] mul_b;
  logic [MULA_W+MULB_W-1:0] mul_p;
  logic [DEN_W:0]    rem_sh;
  logic              div_ge;
  logic [DEN_W:0]    rem_sub;
  logic [DEN_W-1:0]  rem_next;
  logic [QUO_W-1:0]  q_next;
  logic              div_last;
  logic [W_W-1:0]    wout_rnd, win_rnd;
  logic              in_rect;
  logic [WGT_W-1:0]  fix_sat, keep_sat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_cols_r       <= 6'd32;
      grid_rows_r       <= 5'd12;
      inner_col_start_r <= 5'd0;
      inner_row_start_r <= 4'd0;
      inner_cols_r      <= 6'd16;
      inner_rows_r      <= 5'd6;
      inner_share_pct_r <= 7'd50;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_GRID_COLS:       grid_cols_r       <= cfg_wdata[5:0];
        REG_GRID_ROWS:       grid_rows_r       <= cfg_wdata[4:0];
        REG_INNER_COL_START: inner_col_start_r <= cfg_wdata[4:0];
        REG_INNER_ROW_START: inner_row_start_r <= cfg_wdata[3:0];
        REG_INNER_COLS:      inner_cols_r      <= cfg_wdata[5:0];
        REG_INNER_ROWS:      inner_rows_r      <= cfg_wdata[4:0];
        REG_INNER_SHARE_PCT: inner_share_pct_r <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    gc = ({1'b0, grid_cols_r} > 7'(MAX_GRID_COLS)) ? 7'(MAX_GRID_COLS)
                                                  : {1'b0, grid_cols_r};
    gr = ({2'b0, grid_rows_r} > 7'(MAX_GRID_ROWS)) ? 6'(MAX_GRID_ROWS)
                                                  : {1'b0, grid_rows_r};
    if (inner_share_pct_r < PCT_MIN) begin
      pct = PCT_MIN;
    end else if (inner_share_pct_r > PCT_MAX) begin
      pct = PCT_MAX;
    end else begin
      pct = inner_share_pct_r;
    end
    pct_c = PCT_TOTAL - pct;
  end

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_TOTAL: begin
        mul_a = MULA_W'(gc);
        mul_b = MULB_W'(gr);
      end
      ST_NIN: begin
        mul_a = MULA_W'(inner_cols_r);
        mul_b = MULB_W'(inner_rows_r);
      end
      ST_PROD1: begin
        mul_a = (win_r > wout_r) ? MULA_W'(wout_r) : MULA_W'(win_r);
        mul_b = (win_r > wout_r) ? nout_r : nin_r;
      end
      ST_PROD2: begin
        mul_a = prod_r[MULA_W-1:0];
        mul_b = sel_in_r ? MULB_W'(pct) : MULB_W'(pct_c);
      end
      ST_DEN: begin
        mul_a = sel_in_r ? MULA_W'(nin_r) : MULA_W'(nout_r);
        mul_b = sel_in_r ? MULB_W'(pct_c) : MULB_W'(pct);
      end
      default: ;
    endcase
    mul_p = mul_a * mul_b;
  end

  // shared divider step
  always_comb begin
    rem_sh   = {div_rem_r, div_q_r[QUO_W-1]};
    div_ge   = rem_sh >= {1'b0, div_d_r};
    rem_sub  = rem_sh - {1'b0, div_d_r};
    rem_next = div_ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    q_next   = {div_q_r[QUO_W-2:0], div_ge};
    div_last = div_cnt_r == ITER_W'(1);
  end

  function automatic logic [W_W-1:0] round_shift(input logic [W_W-1:0] v,
                                                 input logic [SH_W-1:0] s);
    logic [W_W:0] sum;
    logic [W_W:0] bias;
    begin
      bias = (s == '0) ? '0 : ((W_W+1)'(1) << (s - SH_W'(1)));
      sum  = {1'b0, v} + bias;
      return W_W'(sum >> s);
    end
  endfunction

  always_comb begin
    wout_rnd = round_shift(wout_r, sh_r);
    win_rnd  = round_shift(win_r, sh_r);
    in_rect = ({1'b0, row_r} >= {1'b0, inner_row_start_r})
          && ({2'b0, row_r} < ({2'b0, inner_row_start_r} + {1'b0, inner_rows_r}))
          && ({1'b0, col_r} >= {1'b0, inner_col_start_r})
          && ({2'b0, col_r} < ({2'b0, inner_col_start_r} + {1'b0, inner_cols_r}));
    fix_sat  = (|q_next[QUO_W-1:WGT_W]) ? WGT_MAX : q_next[WGT_W-1:0];
    keep_sat = sel_in_r ? ((|wout_r[W_W-1:WGT_W]) ? WGT_MAX : wout_r[WGT_W-1:0])
                        : ((|win_r[W_W-1:WGT_W])  ? WGT_MAX : win_r[WGT_W-1:0]);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (in_chan.valid) state_nxt = ST_TOTAL;
      ST_TOTAL:   state_nxt = ST_NIN;
      ST_NIN:     state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (nin_r == '0 || total_r <= nin_r) state_nxt = ST_OUT;
        else state_nxt = ST_DIV_OUT;
      end
      ST_DIV_OUT: if (div_last) state_nxt = ST_DIV_IN;
      ST_DIV_IN:  if (div_last) state_nxt = ST_NORM;
      ST_NORM:    if (big_r < W_W'(WGT_MAX)) state_nxt = ST_ROUND;
      ST_ROUND:   state_nxt = ST_PROD1;
      ST_PROD1:   state_nxt = ST_PROD2;
      ST_PROD2:   state_nxt = ST_DEN;
      ST_DEN:     state_nxt = ST_DIV_FIX;
      ST_DIV_FIX: if (div_last) state_nxt = ST_OUT;
      ST_OUT:     if (out_chan.ready) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_chan.ready         = state_r == ST_IDLE;
    out_chan.valid        = state_r == ST_OUT;
    out_chan.cell_weight  = weight_r;
    out_chan.region_error = err_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        row_r <= in_chan.cell_row;
        col_r <= in_chan.cell_col;
      end
      ST_TOTAL: total_r <= mul_p[CNT_W-1:0];
      ST_NIN:   nin_r   <= mul_p[CNT_W-1:0];
      ST_CHECK: begin
        nout_r    <= total_r - nin_r;
        weight_r  <= '0;
        err_r     <= 1'b1;
        div_q_r   <= {pct_c, SCALE_SH'(0), (QUO_W-W_W)'(0)};
        div_rem_r <= '0;
        div_d_r   <= DEN_W'(total_r - nin_r);
        div_cnt_r <= ITER_W'(W_W);
      end
      ST_DIV_OUT: begin
        div_cnt_r <= div_cnt_r - ITER_W'(1);
        if (div_last) begin
          wout_r    <= q_next[W_W-1:0];
          div_q_r   <= {pct, SCALE_SH'(0), (QUO_W-W_W)'(0)};
          div_rem_r <= '0;
          div_d_r   <= DEN_W'(nin_r);
          div_cnt_r <= ITER_W'(W_W);
        end else begin
          div_q_r   <= q_next;
          div_rem_r <= rem_next;
        end
      end
      ST_DIV_IN: begin
        div_cnt_r <= div_cnt_r - ITER_W'(1);
        div_q_r   <= q_next;
        div_rem_r <= rem_next;
        if (div_last) begin
          win_r <= q_next[W_W-1:0];
          big_r <= (wout_r > q_next[W_W-1:0]) ? wout_r : q_next[W_W-1:0];
          sh_r  <= '0;
        end
      end
      ST_NORM: begin
        if (big_r >= W_W'(WGT_MAX)) begin
          big_r <= W_W'(({1'b0, big_r} + (W_W+1)'(1)) >> 1);
          sh_r  <= sh_r + SH_W'(1);
        end
      end
      ST_ROUND: begin
        wout_r <= wout_rnd;
        win_r  <= win_rnd;
      end
      ST_PROD1: begin
        sel_in_r <= win_r > wout_r;
        prod_r   <= QUO_W'(mul_p);
      end
      ST_PROD2: prod_r <= QUO_W'(mul_p);
      ST_DEN: begin
        div_q_r   <= prod_r;
        div_rem_r <= '0;
        div_d_r   <= DEN_W'(mul_p);
        div_cnt_r <= ITER_W'(QUO_W);
      end
      ST_DIV_FIX: begin
        div_cnt_r <= div_cnt_r - ITER_W'(1);
        div_q_r   <= q_next;
        div_rem_r <= rem_next;
        if (div_last) begin
          err_r <= 1'b0;
          if (in_rect == sel_in_r) weight_r <= fix_sat;
          else weight_r <= keep_sat;
        end
      end
      ST_OUT: ;
      default: ;
    endcase
  end

  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !out_chan.valid)
    else $error("result raised one cycle after query");

  a_error_zero_weight: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.region_error) |-> (out_chan.cell_weight == '0))
    else $error("region error with non-zero weight");

  a_div_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV_OUT || state_r == ST_DIV_IN || state_r == ST_DIV_FIX)
      |-> (div_cnt_r != '0))
    else $error("divider running with zero step count");

  a_norm_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND) |-> (big_r < W_W'(WGT_MAX)))
    else $error("normalisation left an oversized weight");

endmodule
